### src/nbc_pkg.sv
// shared constants and types for the naive bayes count classifier
package nbc_pkg;

  localparam int DEF_NUM_CLASSES = 4;
  localparam int DEF_NUM_ATTRS   = 6;
  localparam int DEF_VALUE_CODES = 64;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int ATTR_PORTS = 6;
  localparam int CODE_BITS  = 6;
  localparam int LABEL_BITS = 2;

  localparam logic OP_TRAIN    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
  } mul_ctl_t;

endpackage

### src/nbc_pair_mem.sv
// pair count memory with clearing sweep after reset
module nbc_pair_mem #(
  parameter int DEPTH      = nbc_pkg::DEF_NUM_CLASSES * nbc_pkg::DEF_VALUE_CODES,
  parameter int COUNT_BITS = nbc_pkg::DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [COUNT_BITS-1:0]    wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [COUNT_BITS-1:0]    rd_data,
  output logic                     busy
);
  import nbc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic                  clearing;
  logic [AW-1:0]         clr_addr;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/nbc_limb_mul.sv
// shared limb-serial multiplier: wide accumulator times a count value
module nbc_limb_mul #(
  parameter int COUNT_BITS = nbc_pkg::DEF_COUNT_BITS,
  parameter int LIMBS      = 2 * nbc_pkg::DEF_NUM_ATTRS - 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nbc_pkg::mul_ctl_t           ctl,
  input  logic [COUNT_BITS*LIMBS-1:0] load_val,
  input  logic [COUNT_BITS-1:0]       mval,
  output logic [COUNT_BITS*LIMBS-1:0] acc,
  output logic                        done
);
  import nbc_pkg::*;

  localparam int W   = COUNT_BITS * LIMBS;
  localparam int PW  = 2 * COUNT_BITS;
  localparam int LCW = (LIMBS > 1) ? $clog2(LIMBS) : 1;

  logic                  busy;
  logic [LCW-1:0]        cnt;
  logic [COUNT_BITS-1:0] mult;
  logic [COUNT_BITS-1:0] carry;
  logic [PW-1:0]         prod;
  logic [W-1:0]          rot;

  // low limb times multiplier plus carry in
  assign prod = PW'(acc[COUNT_BITS-1:0]) * PW'(mult) + PW'(carry);
  assign done = busy && (cnt == LCW'(LIMBS - 1));

  generate
    if (LIMBS > 1) begin : g_rot
      assign rot = {prod[COUNT_BITS-1:0], acc[W-1:COUNT_BITS]};
    end else begin : g_one
      assign rot = prod[COUNT_BITS-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + LCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= load_val;
    end else if (busy) begin
      acc <= rot;
    end
    if (ctl.start) begin
      mult  <= mval;
      carry <= '0;
    end else if (busy) begin
      carry <= prod[PW-1:COUNT_BITS];
    end
  end

endmodule

### src/naive_bayes_count_classifier_unit.sv
// top level of the categorical naive bayes count classifier
//
// input channel: in_valid / in_stall carries one request (op, class_label,
// attr_0..attr_5). op train adds the sample to the class and pair counts and
// gives no result; op classify gives one result on the output channel.
// output channel: out_valid / out_stall carries predicted_class and found.
// train does one memory read and one write per attribute, T = attributes
// used. classify is paced by the single limb-serial multiplier, with
// L = 2*T - 1 limbs.
// scores are compared exactly: num * best_n^(T-1) against best_num * n^(T-1).
// one request at a time; in_stall is high while a request is being worked.
// reset clears the class counts at once and then sweeps the pair memory,
// all NUM_CLASSES * VALUE_CODES entries, during which in_stall stays high.
// a finished result sits in the output register while the next request is
// taken; if the receiver stalls, a second result waits until it is free.
module naive_bayes_count_classifier_unit #(
  parameter int NUM_CLASSES = nbc_pkg::DEF_NUM_CLASSES,
  parameter int NUM_ATTRS   = nbc_pkg::DEF_NUM_ATTRS,
  parameter int VALUE_CODES = nbc_pkg::DEF_VALUE_CODES,
  parameter int COUNT_BITS  = nbc_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [nbc_pkg::LABEL_BITS-1:0] class_label,
  input  logic [nbc_pkg::CODE_BITS-1:0]  attr_0,
  input  logic [nbc_pkg::CODE_BITS-1:0]  attr_1,
  input  logic [nbc_pkg::CODE_BITS-1:0]  attr_2,
  input  logic [nbc_pkg::CODE_BITS-1:0]  attr_3,
  input  logic [nbc_pkg::CODE_BITS-1:0]  attr_4,
  input  logic [nbc_pkg::CODE_BITS-1:0]  attr_5,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nbc_pkg::LABEL_BITS-1:0] predicted_class,
  output logic                           found
);
  import nbc_pkg::*;

  localparam int T     = (NUM_ATTRS < ATTR_PORTS) ? NUM_ATTRS : ATTR_PORTS;
  localparam int REPS  = T - 1;
  localparam int LIMBS = 2 * T - 1;
  localparam int W     = COUNT_BITS * LIMBS;
  localparam int NW    = COUNT_BITS * T;
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int DEPTH = NUM_CLASSES * VALUE_CODES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_TR_RD, S_TR_WR, S_CL_CLS, S_CL_RD, S_CL_MUL, S_CL_WAIT,
    S_CL_CHK, S_CL_LS, S_CL_LW, S_CL_RS, S_CL_RW, S_CL_CMP, S_CL_NEXT, S_DONE
  } state_t;

  state_t state;

  // request payload
  logic [CODE_BITS-1:0]  attrs [ATTR_PORTS];
  logic [2:0]            attr_idx;
  logic [2:0]            rep;
  logic [CW-1:0]         cur_class;

  // class sample counts, cleared by reset
  logic [COUNT_BITS-1:0] class_cnt [NUM_CLASSES];

  // running best and scratch values
  logic                  best_found;
  logic [CW-1:0]         best;
  logic [COUNT_BITS-1:0] best_n;
  logic [COUNT_BITS-1:0] n_q;
  logic [NW-1:0]         best_num;
  logic [NW-1:0]         num_q;
  logic [W-1:0]          lhs;

  // memory and multiplier hookup
  logic                  mem_busy;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] rd_data;
  logic [AW-1:0]         mem_addr;
  mul_ctl_t              mctl;
  logic [W-1:0]          load_val;
  logic [COUNT_BITS-1:0] mval;
  logic [W-1:0]          acc;
  logic                  mul_done;

  logic                  accept;
  logic                  label_ok;
  logic [CODE_BITS-1:0]  cur_attr;
  logic                  code_ok;
  logic [COUNT_BITS-1:0] cur_n;
  logic                  acc_zero;
  logic                  last_attr;
  logic                  last_rep;
  logic                  take_chk;
  logic                  take_cmp;

  assign in_stall  = (state != S_IDLE) || mem_busy;
  assign accept    = in_valid && !in_stall;
  assign label_ok  = 5'(class_label) < 5'(NUM_CLASSES);
  assign cur_attr  = attrs[attr_idx];
  assign code_ok   = 9'(cur_attr) < 9'(VALUE_CODES);
  assign cur_n     = class_cnt[cur_class];
  assign acc_zero  = (acc == '0);
  assign last_attr = (attr_idx == 3'(T - 1));
  assign last_rep  = (rep == 3'(REPS - 1));
  assign mem_addr  = AW'(cur_class) * AW'(VALUE_CODES) + AW'(cur_attr);

  // pair count update saturates at the top
  assign wr_en   = (state == S_TR_WR) && code_ok;
  assign wr_data = (rd_data == CNT_MAX) ? rd_data : rd_data + COUNT_BITS'(1);

  // first class with a nonzero score is taken; later ones only if strictly greater
  always_comb begin
    take_chk = 1'b0;
    if (state == S_CL_CHK && !acc_zero) begin
      if (!best_found) begin
        take_chk = 1'b1;
      end else if (REPS == 0) begin
        take_chk = W'(best_num) < acc;
      end
    end
  end
  assign take_cmp = (state == S_CL_CMP) && (lhs > acc);

  always_comb begin
    mctl     = '0;
    load_val = '0;
    mval     = '0;
    case (state)
      S_CL_CLS: begin
        if (cur_n != '0) begin
          mctl.load = 1'b1;
          load_val  = W'(1);
        end
      end
      S_CL_MUL: begin
        mctl.start = 1'b1;
        mval       = code_ok ? rd_data : '0;
      end
      S_CL_LS: begin
        mctl.start = 1'b1;
        mval       = best_n;
      end
      S_CL_RS: begin
        // lhs is complete here; first pass reloads the best numerator
        if (rep == '0) begin
          mctl.load = 1'b1;
          load_val  = W'(best_num);
        end
        mctl.start = 1'b1;
        mval       = n_q;
      end
      default: begin
        mctl = '0;
      end
    endcase
  end

  nbc_pair_mem #(
    .DEPTH      (DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (mem_addr),
    .wr_data (wr_data),
    .rd_addr (mem_addr),
    .rd_data (rd_data),
    .busy    (mem_busy)
  );

  nbc_limb_mul #(
    .COUNT_BITS (COUNT_BITS),
    .LIMBS      (LIMBS)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mctl),
    .load_val (load_val),
    .mval     (mval),
    .acc      (acc),
    .done     (mul_done)
  );

  // sequencer, class counts and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      attr_idx        <= '0;
      rep             <= '0;
      cur_class       <= '0;
      best_found      <= 1'b0;
      best            <= '0;
      out_valid       <= 1'b0;
      predicted_class <= '0;
      found           <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        class_cnt[k] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (take_chk || take_cmp) begin
        best_found <= 1'b1;
        best       <= cur_class;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            attr_idx <= '0;
            if (op == OP_CLASSIFY) begin
              cur_class  <= '0;
              best_found <= 1'b0;
              best       <= '0;
              state      <= S_CL_CLS;
            end else if (label_ok) begin
              cur_class <= CW'(class_label);
              state     <= S_TR_RD;
            end
          end
        end
        S_TR_RD: begin
          if (attr_idx == '0 && cur_n != CNT_MAX) begin
            class_cnt[cur_class] <= cur_n + COUNT_BITS'(1);
          end
          state <= S_TR_WR;
        end
        S_TR_WR: begin
          if (last_attr) begin
            state <= S_IDLE;
          end else begin
            attr_idx <= attr_idx + 3'd1;
            state    <= S_TR_RD;
          end
        end
        S_CL_CLS: begin
          attr_idx <= '0;
          // a class without samples scores zero
          state    <= (cur_n == '0) ? S_CL_NEXT : S_CL_RD;
        end
        S_CL_RD: begin
          state <= S_CL_MUL;
        end
        S_CL_MUL: begin
          state <= S_CL_WAIT;
        end
        S_CL_WAIT: begin
          if (mul_done) begin
            if (last_attr) begin
              state <= S_CL_CHK;
            end else begin
              attr_idx <= attr_idx + 3'd1;
              state    <= S_CL_RD;
            end
          end
        end
        S_CL_CHK: begin
          rep <= '0;
          if (acc_zero || !best_found || REPS == 0) begin
            state <= S_CL_NEXT;
          end else begin
            state <= S_CL_LS;
          end
        end
        S_CL_LS: begin
          state <= S_CL_LW;
        end
        S_CL_LW: begin
          if (mul_done) begin
            if (last_rep) begin
              rep   <= '0;
              state <= S_CL_RS;
            end else begin
              rep   <= rep + 3'd1;
              state <= S_CL_LS;
            end
          end
        end
        S_CL_RS: begin
          state <= S_CL_RW;
        end
        S_CL_RW: begin
          if (mul_done) begin
            if (last_rep) begin
              state <= S_CL_CMP;
            end else begin
              rep   <= rep + 3'd1;
              state <= S_CL_RS;
            end
          end
        end
        S_CL_CMP: begin
          state <= S_CL_NEXT;
        end
        S_CL_NEXT: begin
          if (cur_class == CW'(NUM_CLASSES - 1)) begin
            state <= S_DONE;
          end else begin
            cur_class <= cur_class + CW'(1);
            state     <= S_CL_CLS;
          end
        end
        S_DONE: begin
          // wait for a free output register
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            predicted_class <= best_found ? LABEL_BITS'(best) : '0;
            found           <= best_found;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      attrs[0] <= attr_0;
      attrs[1] <= attr_1;
      attrs[2] <= attr_2;
      attrs[3] <= attr_3;
      attrs[4] <= attr_4;
      attrs[5] <= attr_5;
    end
    if (state == S_CL_CLS) begin
      n_q <= cur_n;
    end
    if (state == S_CL_CHK) begin
      num_q <= acc[NW-1:0];
    end
    if (state == S_CL_RS && rep == '0) begin
      lhs <= acc;
    end
    if (take_chk) begin
      best_num <= acc[NW-1:0];
      best_n   <= n_q;
    end else if (take_cmp) begin
      best_num <= num_q;
      best_n   <= n_q;
    end
  end

endmodule
